[hdl/assert_macros.svh]
// Assertion macros shared by the interval timer modules.
// No dependencies; assertions are removed when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Expression must hold at every clock edge outside reset.
`define RIT_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// Consequent must hold at the clock edge after the antecedent.
`define RIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RIT_ASSERT(label, clk, rst_n, expr)
`define RIT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/rit_pkg.sv]
// Shared types and codes for the repeating interval timer.
// No dependencies.
package rit_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_RESET = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_PERIODIC = 2'd1,
        EV_COMPLETE = 2'd2
    } event_e;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_DELAY = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 3;

    // One command beat handed from the input register to the timer state.
    typedef struct packed {
        logic go;
        cmd_e cmd;
    } step_t;

endpackage

[hdl/rit_regs.sv]
// Configuration registers of the interval timer behind an APB-style port.
// Depends on rit_pkg.
module rit_regs #(
    parameter int TICK_WIDTH  = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rit_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [rit_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [rit_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                 pready,
    output logic [TICK_WIDTH-1:0]                delay,
    output logic [COUNT_WIDTH-1:0]               limit,
    output logic                                 clear_count
);
    import rit_pkg::*;

    logic [TICK_WIDTH-1:0]  delay_reg;
    logic [COUNT_WIDTH-1:0] limit_reg;
    logic                   wr_en;
    logic                   index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = paddr[2];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            delay_reg <= '0;
            limit_reg <= '0;
        end
        else if (wr_en)
        begin
            if (index == REG_DELAY)
            begin
                delay_reg <= pwdata[TICK_WIDTH-1:0];
            end
            else
            begin
                limit_reg <= pwdata[COUNT_WIDTH-1:0];
            end
        end
    end

    // A repeat limit write restarts the firing count.
    assign clear_count = wr_en && (index == REG_LIMIT);

    always_comb begin
        if (index == REG_DELAY)
        begin
            prdata = APB_DATA_WIDTH'(delay_reg);
        end
        else
        begin
            prdata = APB_DATA_WIDTH'(limit_reg);
        end
    end

    assign delay = delay_reg;
    assign limit = limit_reg;

endmodule

[hdl/rit_core.sv]
// Timer state (interval, fire count, running flag) and the per-command update.
// Depends on rit_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rit_core #(
    parameter int TICK_WIDTH  = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rit_pkg::step_t         step,
    input  logic [TICK_WIDTH-1:0]  elapsed,
    input  logic [TICK_WIDTH-1:0]  delay,
    input  logic [COUNT_WIDTH-1:0] limit,
    input  logic                   clear_count,
    output rit_pkg::event_e        event_kind,
    output logic [COUNT_WIDTH-1:0] fire_count,
    output logic                   is_running
);
    import rit_pkg::*;

    localparam int ACC_WIDTH = TICK_WIDTH + 1;

    logic [ACC_WIDTH-1:0]   acc_reg, acc_next, acc_sum;
    logic [COUNT_WIDTH-1:0] count_reg, count_next, count_inc;
    logic                   run_reg, run_next;
    logic                   hit, below;
    event_e                 ev;

    assign acc_sum   = ACC_WIDTH'(acc_reg + {1'b0, elapsed});
    assign hit       = acc_sum >= {1'b0, delay};
    assign count_inc = COUNT_WIDTH'(count_reg + 1'b1);
    assign below     = (limit == '0) || (count_inc < limit);

    always_comb begin
        acc_next   = acc_reg;
        count_next = count_reg;
        run_next   = run_reg;
        ev         = EV_NONE;
        if (step.go)
        begin
            case (step.cmd)
                CMD_TICK:
                begin
                    if (run_reg)
                    begin
                        if (hit)
                        begin
                            acc_next   = '0;
                            count_next = count_inc;
                            if (below)
                            begin
                                ev = EV_PERIODIC;
                            end
                            else
                            begin
                                // Final repeat, or a count already past the limit.
                                run_next = 1'b0;
                                ev = (count_inc == limit) ? EV_COMPLETE : EV_NONE;
                            end
                        end
                        else
                        begin
                            acc_next = acc_sum;
                        end
                    end
                end
                CMD_START:
                begin
                    run_next = 1'b1;
                    acc_next = '0;
                end
                CMD_STOP:
                begin
                    run_next = 1'b0;
                    acc_next = '0;
                end
                CMD_RESET:
                begin
                    count_next = '0;
                    acc_next   = '0;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= '0;
            run_reg   <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            run_reg <= run_next;
            if (clear_count)
            begin
                count_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
            end
        end
    end

    assign event_kind = ev;
    assign fire_count = count_next;
    assign is_running = run_next;

    `RIT_ASSERT_NEXT(a_start_runs, clk, rst_n,
        step.go && step.cmd == CMD_START, run_reg && acc_reg == '0)
    `RIT_ASSERT_NEXT(a_stop_halts, clk, rst_n,
        step.go && step.cmd == CMD_STOP, !run_reg && acc_reg == '0)
    `RIT_ASSERT(a_fire_clears_acc, clk, rst_n,
        ev == EV_NONE || acc_next == '0)

endmodule

[hdl/repeating_interval_timer.sv]
// Top level of the repeating interval timer: input register, timer core, result register.
// Depends on rit_pkg, rit_regs, rit_core and assert_macros.svh.
//
// Usage:
// Each input beat carries one command (tick with elapsed_ticks, start, stop or
// reset count) on a valid/stall channel; each accepted beat yields exactly one
// result beat with event_kind, fire_count and is_running after that command.
// The delay and repeat limit are set through the APB-style port; the user must
// write them only while the block is idle, which the block itself does not enforce.
// Writing the repeat limit also clears the fire count. A command accepted at a clock
// edge is held in the input register; its result is captured in the result register
// when the held command advances, which a stalled receiver can hold back, and is then
// presented on the result channel.
// Throughput: one command per cycle while out_stall is low. The interval add, the
// delay compare and the count update all sit between the input and result registers.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more command; after that in_stall is raised
// until the result beat drains.
// Reset clears the timer state, both configuration registers and both valid
// flags; the timer comes out of reset stopped with a zero count.
`include "assert_macros.svh"
module repeating_interval_timer #(
    parameter int TICK_WIDTH  = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rit_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [rit_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [rit_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           command,
    input  logic [TICK_WIDTH-1:0]                elapsed_ticks,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           event_kind,
    output logic [COUNT_WIDTH-1:0]               fire_count,
    output logic                                 is_running
);
    import rit_pkg::*;

    // Input register.
    logic                   in_valid_reg;
    cmd_e                   cmd_reg;
    logic [TICK_WIDTH-1:0]  elapsed_reg;

    // Result register.
    logic                   out_valid_reg;
    event_e                 event_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic                   running_reg;

    logic                   advance;
    step_t                  step;
    logic [TICK_WIDTH-1:0]  delay;
    logic [COUNT_WIDTH-1:0] limit;
    logic                   clear_count;
    event_e                 core_event;
    logic [COUNT_WIDTH-1:0] core_count;
    logic                   core_running;

    // The held command moves into the result register whenever that register
    // is empty or its beat is being taken in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    assign step.go  = advance;
    assign step.cmd = cmd_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && !in_stall)
        begin
            cmd_reg     <= cmd_e'(command);
            elapsed_reg <= elapsed_ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (advance)
        begin
            event_reg   <= core_event;
            count_reg   <= core_count;
            running_reg <= core_running;
        end
    end

    rit_regs #(
        .TICK_WIDTH  (TICK_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .delay       (delay),
        .limit       (limit),
        .clear_count (clear_count)
    );

    rit_core #(
        .TICK_WIDTH  (TICK_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .elapsed     (elapsed_reg),
        .delay       (delay),
        .limit       (limit),
        .clear_count (clear_count),
        .event_kind  (core_event),
        .fire_count  (core_count),
        .is_running  (core_running)
    );

    assign out_valid  = out_valid_reg;
    assign event_kind = event_reg;
    assign fire_count = count_reg;
    assign is_running = running_reg;

    `RIT_ASSERT(a_periodic_running, clk, rst_n,
        !out_valid_reg || event_reg != EV_PERIODIC || running_reg)
    `RIT_ASSERT(a_complete_stopped, clk, rst_n,
        !out_valid_reg || event_reg != EV_COMPLETE || !running_reg)
    `RIT_ASSERT_NEXT(a_advance_fills, clk, rst_n, advance, out_valid_reg)

endmodule
